// ===== rtl/choa_pkg.sv =====
// Types, constants and the month-length function shared by the
// calendar hour offset adder. No dependencies.
`default_nettype none

package choa_pkg;

    localparam logic [12:0] YEAR_MAX   = 13'd8099;
    localparam logic [13:0] YEAR_BASE  = 14'd1900;
    localparam logic [3:0]  MONTH_MAX  = 4'd11;
    localparam logic [4:0]  HOUR_MAX   = 5'd23;
    localparam logic [4:0]  HOURS_DAY  = 5'd24;
    localparam logic signed [5:0] OFFSET_MAX = 6'sd23;
    localparam logic signed [5:0] OFFSET_MIN = -6'sd23;

    // floor(y / 25) = (y * DIV25_MUL) >> DIV25_SHIFT, exact for y below 2^14
    localparam logic [14:0] DIV25_MUL   = 15'd20972;
    localparam int          DIV25_SHIFT = 19;

    localparam logic [3:0] MON_JAN = 4'd0;
    localparam logic [3:0] MON_FEB = 4'd1;
    localparam logic [3:0] MON_APR = 4'd3;
    localparam logic [3:0] MON_JUN = 4'd5;
    localparam logic [3:0] MON_SEP = 4'd8;
    localparam logic [3:0] MON_NOV = 4'd10;
    localparam logic [3:0] MON_DEC = 4'd11;

    localparam logic [4:0] DAYS_LONG  = 5'd31;
    localparam logic [4:0] DAYS_SHORT = 5'd30;
    localparam logic [4:0] DAYS_LEAP  = 5'd29;
    localparam logic [4:0] DAYS_FEB   = 5'd28;

    // One item as it moves down the pipeline; fields fill in stage by stage
    typedef struct packed {
        logic [12:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [4:0]  shifted_hour;
        logic        fwd;
        logic        back;
        logic        leap;
        logic [4:0]  last;
    } choa_item_t;

    typedef struct packed {
        logic [12:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic        err;
    } choa_res_t;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = DAYS_LONG;
        case (month) inside
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAYS_SHORT;
            MON_FEB:                            len = leap ? DAYS_LEAP : DAYS_FEB;
            default:                            len = DAYS_LONG;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/choa_roll.sv =====
// Day, month and year carry/borrow for one item whose fields are clamped.
// Depends on choa_pkg.
`default_nettype none

module choa_roll (
    input  wire choa_pkg::choa_item_t item,
    output choa_pkg::choa_res_t       res
);

    always_comb
    begin
        logic [12:0] ny;
        logic [3:0]  nm;
        logic [4:0]  nd;
        logic        err;
        ny  = item.year;
        nm  = item.month;
        nd  = item.day;
        err = 1'b0;
        if (item.back)
        begin
            if (item.day > 5'd1)
            begin
                nd = item.day - 5'd1;
            end
            else if (item.month != choa_pkg::MON_JAN)
            begin
                nm = item.month - 4'd1;
                nd = choa_pkg::month_len(nm, item.leap);
            end
            else if (item.year != 13'd0)
            begin
                nm = choa_pkg::MON_DEC;
                ny = item.year - 13'd1;
                nd = choa_pkg::DAYS_LONG;
            end
            else
            begin
                err = 1'b1;
            end
        end
        else if (item.fwd)
        begin
            if (item.day < item.last)
            begin
                nd = item.day + 5'd1;
            end
            else if (item.month < choa_pkg::MONTH_MAX)
            begin
                nm = item.month + 4'd1;
                nd = 5'd1;
            end
            else if (item.year < choa_pkg::YEAR_MAX)
            begin
                nm = choa_pkg::MON_JAN;
                ny = item.year + 13'd1;
                nd = 5'd1;
            end
            else
            begin
                err = 1'b1;
            end
        end
        // keep the clamped input date and hour when the year would leave range
        if (err)
        begin
            res.year  = item.year;
            res.month = item.month;
            res.day   = item.day;
            res.hour  = item.hour;
        end
        else
        begin
            res.year  = ny;
            res.month = nm;
            res.day   = nd;
            res.hour  = item.shifted_hour;
        end
        res.err = err;
    end

endmodule

`default_nettype wire

// ===== rtl/calendar_hour_offset_adder.sv =====
// Top level of the calendar hour offset adder: four-stage pipeline.
// Depends on choa_pkg and choa_roll.
//
// Adds a signed hour offset (-23..23) to a Gregorian date and hour, given
// as years since 1900, month 0..11, day and hour, and returns the shifted
// date and hour. A shift past midnight moves one day forward or back and
// carries into the month and year; February follows the 4/100/400 leap
// rule on the calendar year. Out-of-range inputs are clamped first (year
// to 8099, month to 11, day to 1..month length, hour to 23, offset to
// +/-23). If the shift would leave years 0..8099 the unshifted, clamped
// date and hour come back with range_error set. One transfer is taken per
// cycle unless back-pressure has filled every stage. Four registered
// stages: 1) clamp, hour sum and the 14x15 reciprocal multiply,
// 2) modulo-25 correction and leap test, 3) month length and day clamp,
// 4) carry/borrow into the output register. A full stage holds only while
// the one after it holds, so bubbles close up under back-pressure.
`default_nettype none

module calendar_hour_offset_adder (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    // [12:0] year_since_1900, [16:13] month_index, [21:17] day_of_month,
    // [26:22] hour_of_day, [32:27] offset_hours, [39:33] zero
    input  wire [39:0] s_tdata,
    output logic       m_tvalid,
    input  wire        m_tready,
    // [12:0] new_year, [16:13] new_month, [21:17] new_day, [26:22] new_hour,
    // [31:27] zero
    output logic [31:0] m_tdata,
    // [0] range_error
    output logic [0:0] m_tuser
);

    // Stage valids and enables: a stage advances when it is empty or its
    // successor takes its contents this cycle
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    assign en4 = !v4_reg || m_tready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_tready = en1;

    // ---------------- Stage 1: clamp, hour sum, multiply ----------------
    logic [12:0]        year_in;
    logic [3:0]         month_in;
    logic [4:0]         day_in;
    logic [4:0]         hour_in;
    logic signed [5:0]  off_in;
    logic signed [5:0]  off_sat;
    logic signed [6:0]  hour_sum;
    logic signed [6:0]  hour_adj;
    logic [13:0]        cyear;
    choa_pkg::choa_item_t s1_next, s1_reg;
    logic [13:0]        s1_cyear_next, s1_cyear_reg;
    logic [28:0]        s1_prod_next, s1_prod_reg;

    assign year_in  = s_tdata[12:0];
    assign month_in = s_tdata[16:13];
    assign day_in   = s_tdata[21:17];
    assign hour_in  = s_tdata[26:22];
    assign off_in   = s_tdata[32:27];

    always_comb
    begin
        s1_next       = '0;
        s1_next.year  = (year_in > choa_pkg::YEAR_MAX) ? choa_pkg::YEAR_MAX : year_in;
        s1_next.month = (month_in > choa_pkg::MONTH_MAX) ? choa_pkg::MONTH_MAX : month_in;
        s1_next.day   = day_in;
        s1_next.hour  = (hour_in > choa_pkg::HOUR_MAX) ? choa_pkg::HOUR_MAX : hour_in;

        if (off_in < choa_pkg::OFFSET_MIN)
            off_sat = choa_pkg::OFFSET_MIN;
        else if (off_in > choa_pkg::OFFSET_MAX)
            off_sat = choa_pkg::OFFSET_MAX;
        else
            off_sat = off_in;

        hour_sum = signed'({2'b00, s1_next.hour}) + signed'({off_sat[5], off_sat});
        s1_next.back = hour_sum[6];
        s1_next.fwd  = !hour_sum[6] && (hour_sum > signed'({2'b00, choa_pkg::HOUR_MAX}));
        if (s1_next.back)
            hour_adj = hour_sum + signed'({2'b00, choa_pkg::HOURS_DAY});
        else if (s1_next.fwd)
            hour_adj = hour_sum - signed'({2'b00, choa_pkg::HOURS_DAY});
        else
            hour_adj = hour_sum;
        s1_next.shifted_hour = hour_adj[4:0];

        cyear         = {1'b0, s1_next.year} + choa_pkg::YEAR_BASE;
        s1_cyear_next = cyear;
        s1_prod_next  = 29'(cyear) * 29'(choa_pkg::DIV25_MUL);
    end

    // ---------------- Stage 2: modulo 25 and leap test ----------------
    logic [9:0]  quot25;
    logic [13:0] quot25_x25;
    logic [13:0] rem25;
    logic        div25;
    choa_pkg::choa_item_t s2_next, s2_reg;

    always_comb
    begin
        quot25     = s1_prod_reg[28:choa_pkg::DIV25_SHIFT];
        quot25_x25 = 14'({quot25, 4'b0000}) + 14'({quot25, 3'b000}) + 14'(quot25);
        rem25      = s1_cyear_reg - quot25_x25;
        div25      = (rem25 == 14'd0);
        s2_next    = s1_reg;
        // divisible by 400 is divisible by both 16 and 25
        s2_next.leap = (s1_cyear_reg[1:0] == 2'b00)
                       && (!div25 || (s1_cyear_reg[3:0] == 4'b0000));
    end

    // ---------------- Stage 3: month length, day clamp ----------------
    logic [4:0] month_last;
    choa_pkg::choa_item_t s3_next, s3_reg;

    always_comb
    begin
        month_last   = choa_pkg::month_len(s2_reg.month, s2_reg.leap);
        s3_next      = s2_reg;
        s3_next.last = month_last;
        if (s2_reg.day == 5'd0)
            s3_next.day = 5'd1;
        else if (s2_reg.day > month_last)
            s3_next.day = month_last;
        else
            s3_next.day = s2_reg.day;
    end

    // ---------------- Stage 4: carry and borrow ----------------
    choa_pkg::choa_res_t res_next, res_reg;

    choa_roll u_roll (
        .item (s3_reg),
        .res  (res_next)
    );

    // Valid bits: cleared by reset, advance with their stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // Payload: hold while the stage is stalled
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg       <= s1_next;
            s1_cyear_reg <= s1_cyear_next;
            s1_prod_reg  <= s1_prod_next;
        end
        if (en2) s2_reg  <= s2_next;
        if (en3) s3_reg  <= s3_next;
        if (en4) res_reg <= res_next;
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {5'b00000, res_reg.hour, res_reg.day, res_reg.month, res_reg.year};
    assign m_tuser  = res_reg.err;

    // ---------------- Assertions ----------------
    // Input stalls only when every stage holds an item
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (v1_reg && v2_reg && v3_reg && v4_reg))
        else $error("input stalled with an empty pipeline stage");

    // A range error is only possible at the first or last day of the range
    a_err_edge: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && res_reg.err) |->
            ((res_reg.year == 13'd0 && res_reg.month == choa_pkg::MON_JAN
              && res_reg.day == 5'd1)
             || (res_reg.year == choa_pkg::YEAR_MAX && res_reg.month == choa_pkg::MON_DEC
                 && res_reg.day == choa_pkg::DAYS_LONG)))
        else $error("range error away from the range boundary");

    // Results stay within a valid calendar
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (res_reg.hour <= choa_pkg::HOUR_MAX
                      && res_reg.month <= choa_pkg::MONTH_MAX
                      && res_reg.day != 5'd0
                      && res_reg.year <= choa_pkg::YEAR_MAX))
        else $error("result outside calendar range");

    // A stalled result stays in place
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(res_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
